/* rtl/core/lcdws_pkg.sv */
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants of the character-LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdws_pkg;

  typedef enum logic [1:0] {
    CMD_INSTR = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_POS   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Register indexes on the configuration port.
  localparam logic REG_EIGHT_BIT = 1'b0;
  localparam logic REG_UPPER     = 1'b1;

  localparam int unsigned AddrWidth = 3;

  localparam logic [7:0] SetPosBit = 8'h80;

  // Row start addresses of a four-line display.
  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      default: off = 8'h50;
    endcase
    return off;
  endfunction

  // One classified request as it waits for the pin sequencer.
  typedef struct packed {
    logic       reg_select;
    logic [7:0] data;
    logic       eight_bit;
    logic       upper;
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/lcdws_if.sv */
// ----------------------------------------------------------------------------
// lcdws_if
// Valid/ready channels: requests in, pin updates out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [5:0] column;

  modport source (output valid, command, byte_value, row, column, input ready);
  modport sink   (input valid, command, byte_value, row, column, output ready);
endinterface

interface lcdws_pin_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       read_write;
  logic       enable_pin;
  logic [7:0] data_pins;
  logic       last;

  modport source (output valid, reg_select, read_write, enable_pin, data_pins, last,
                  input ready);
  modport sink   (input valid, reg_select, read_write, enable_pin, data_pins, last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/char_lcd_write_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns instruction, character and cursor requests into LCD write pin updates.
// ----------------------------------------------------------------------------
//   Channel   Direction  Transaction
//   req_i     in         one request: command, byte_value, row, column
//   pins_o    out        one pin update: RS, RW, EN, data port, last
//   APB       in/out     register writes and reads, pready tied high
//
// A request yields four pin updates in 8-bit mode and eight in 4-bit mode,
// one per cycle from the sequencer while pins_o is not held by a low ready.
// A two-entry queue lets requests be accepted while the sequencer works.
// The output register is reloaded in the cycle it is taken.
// Reset clears the data latch and sets both mode bits to one.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer
  import lcdws_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lcdws_req_if.sink            req_i,
  lcdws_pin_if.source          pins_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic eight_bit_q, upper_q;
  logic wr_en, push, full, pop, q_valid;
  job_t push_job, head_job;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_bit_q <= 1'b1;
      upper_q     <= 1'b1;
    end else if (wr_en) begin
      if (paddr[2] == REG_EIGHT_BIT) eight_bit_q <= pwdata[0];
      if (paddr[2] == REG_UPPER)     upper_q     <= pwdata[0];
    end
  end

  assign prdata = {31'd0, (paddr[2] == REG_UPPER) ? upper_q : eight_bit_q};

  lcdws_front u_front (
    .req_i       (req_i),
    .eight_bit_i (eight_bit_q),
    .upper_i     (upper_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  lcdws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  lcdws_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .pins_o  (pins_o)
  );

endmodule

`default_nettype wire

/* rtl/core/lcdws_front.sv */
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, drops unknown commands and forms the byte to be written.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_front
  import lcdws_pkg::*;
(
  lcdws_req_if.sink  req_i,
  input  logic       eight_bit_i,
  input  logic       upper_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic       known;
  logic [7:0] pos_byte;

  assign req_i.ready = ~full_i;

  always_comb begin
    pos_byte = ({2'b00, req_i.column} + row_offset(req_i.row)) | SetPosBit;
    known    = 1'b1;
    job_o.reg_select = 1'b0;
    job_o.data       = req_i.byte_value;
    job_o.eight_bit  = eight_bit_i;
    job_o.upper      = upper_i;
    case (cmd_e'(req_i.command))
      CMD_INSTR: job_o.reg_select = 1'b0;
      CMD_CHAR:  job_o.reg_select = 1'b1;
      CMD_POS:   job_o.data = pos_byte;
      default:   known = 1'b0;
    endcase
  end

  // An unknown command is consumed without producing any pin update.
  assign push_o = req_i.valid & ~full_i & known;

endmodule

`default_nettype wire

/* rtl/core/lcdws_fifo.sv */
// ----------------------------------------------------------------------------
// lcdws_fifo
// Two-entry queue of classified requests between front and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_fifo
  import lcdws_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

`default_nettype wire

/* rtl/core/lcdws_back.sv */
// ----------------------------------------------------------------------------
// lcdws_back
// Pin sequencer: steps through the enable pulses of one queued request.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_back
  import lcdws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  lcdws_pin_if.source pins_o
);

  logic [2:0] step_q;
  logic [7:0] latch_q, latch_d;
  logic       out_valid_q;
  logic       rs_q, en_q, last_q;
  logic       load, en_d, last_d;
  logic [1:0] phase;
  logic       second;

  assign phase  = step_q[1:0];
  assign second = step_q[2];
  assign load   = valid_i & (~out_valid_q | pins_o.ready);
  assign pop_o  = load & last_d;

  always_comb begin
    en_d   = (phase == 2'd1) || (phase == 2'd2);
    last_d = (phase == 2'd3) && (job_i.eight_bit || second);
    latch_d = latch_q;
    // The data is placed in the third update of each pulse.
    if (phase == 2'd2) begin
      if (job_i.eight_bit) begin
        latch_d = job_i.data;
      end else if (job_i.upper) begin
        latch_d = {second ? job_i.data[3:0] : job_i.data[7:4], latch_q[3:0]};
      end else begin
        latch_d = {latch_q[7:4], second ? job_i.data[3:0] : job_i.data[7:4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      latch_q     <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= last_d ? 3'd0 : step_q + 3'd1;
        latch_q     <= latch_d;
        out_valid_q <= 1'b1;
      end else if (pins_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= job_i.reg_select;
      en_q   <= en_d;
      last_q <= last_d;
    end
  end

  assign pins_o.valid      = out_valid_q;
  assign pins_o.reg_select = rs_q;
  assign pins_o.read_write = 1'b0;
  assign pins_o.enable_pin = en_q;
  assign pins_o.data_pins  = latch_q;
  assign pins_o.last       = last_q;

endmodule

`default_nettype wire
